[rtl/gmig_pkg.sv]
// Shared types and constants for the grid mesh index generator.
// Used by every rtl file; depends on nothing.
package gmig_pkg;

  localparam int IDX_W   = 17;  // width of one vertex index
  localparam int SIDE_W  = 9;   // width of the grid side register
  localparam int TRI_W   = 3;   // triangle position inside a cell or skirt step
  localparam int IN_W    = 8;   // input tdata width
  localparam int OUT_W   = 56;  // output tdata width
  localparam int OUT_PAD = OUT_W - 3 * IDX_W;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(2);
  localparam int                MIN_SIDE   = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [TRI_W-1:0] tri_pos_t;

  // Triangle positions: first and second of a cell, then the skirt order.
  localparam tri_pos_t TRI_FIRST  = 3'd0;
  localparam tri_pos_t TRI_TOP_A  = 3'd0;
  localparam tri_pos_t TRI_TOP_B  = 3'd1;
  localparam tri_pos_t TRI_RGT_A  = 3'd2;
  localparam tri_pos_t TRI_RGT_B  = 3'd3;
  localparam tri_pos_t TRI_BTM_A  = 3'd4;
  localparam tri_pos_t TRI_BTM_B  = 3'd5;
  localparam tri_pos_t TRI_LFT_A  = 3'd6;
  localparam tri_pos_t TRI_LFT_B  = 3'd7;

  // Side-dependent constants, all taken modulo 2^IDX_W.
  typedef struct packed {
    idx_t n;      // vertices per side
    idx_t nn;     // n*n, first top skirt vertex
    idx_t lrow;   // n*(n-1), first vertex of the last grid row
    idx_t rgt;    // n*(n+1), first right skirt vertex
    idx_t btm;    // n*(n+2), first bottom skirt vertex
    idx_t lft;    // n*(n+3), first left skirt vertex
  } geom_t;

  // Sequencer position as seen by the index logic.
  typedef struct packed {
    logic     skirt;  // 0 grid cells, 1 skirt
    logic     done;   // list ended
    tri_pos_t tpos;   // triangle inside cell or skirt step
    idx_t     col;    // column x in the grid
    idx_t     cnt;    // row y in the grid, edge step i in the skirt
    idx_t     base;   // y*n in the grid, i*n in the skirt
  } seq_t;

  typedef struct packed {
    idx_t a;
    idx_t b;
    idx_t c;
  } tri_t;

endpackage

[rtl/gmig_geom.sv]
// Grid side register with clamping and the registered side constants.
// Depends on gmig_pkg.
module gmig_geom #(
  parameter int MAX_SIDE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [gmig_pkg::SIDE_W-1:0]  wr_data,
  output gmig_pkg::geom_t              geom,
  output logic                         settling
);

  localparam int NW = $clog2(MAX_SIDE + 1);
  localparam int SW = (NW > gmig_pkg::SIDE_W) ? NW : gmig_pkg::SIDE_W;

  logic [gmig_pkg::SIDE_W-1:0] side_r;
  logic                        settle_r;
  logic [SW-1:0]               side_ext;
  logic [SW-1:0]               side_clamp;
  gmig_pkg::idx_t              n;
  gmig_pkg::geom_t             geom_r;
  gmig_pkg::geom_t             geom_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= gmig_pkg::SIDE_RESET;
      settle_r <= 1'b1;
    end else begin
      if (wr_en) begin
        side_r <= wr_data;
      end
      settle_r <= wr_en;
    end
  end

  always_comb begin
    side_ext = SW'(side_r);
    if (side_ext < SW'(gmig_pkg::MIN_SIDE)) begin
      side_clamp = SW'(gmig_pkg::MIN_SIDE);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      side_clamp = SW'(MAX_SIDE);
    end else begin
      side_clamp = side_ext;
    end
    n             = gmig_pkg::idx_t'(side_clamp);
    geom_nxt.n    = n;
    geom_nxt.nn   = n * n;
    geom_nxt.lrow = n * (n - gmig_pkg::idx_t'(1));
    geom_nxt.rgt  = n * (n + gmig_pkg::idx_t'(1));
    geom_nxt.btm  = n * (n + gmig_pkg::idx_t'(2));
    geom_nxt.lft  = n * (n + gmig_pkg::idx_t'(3));
  end

  // Constants are registered from the side register and follow it in the next cycle.
  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom     = geom_r;
  assign settling = settle_r;

endmodule

[rtl/gmig_seq.sv]
// Position counters of the triangle list: cell or skirt step, triangle, done.
// Depends on gmig_pkg.
module gmig_seq #(
  parameter int MAX_SIDE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              step,
  input  logic              restart,
  input  gmig_pkg::idx_t    n,
  output gmig_pkg::seq_t    cur,
  output logic              last
);

  localparam int CW = $clog2(MAX_SIDE);

  logic               skirt_r, skirt_nxt, skirt_e;
  logic               done_r, done_nxt, done_e;
  gmig_pkg::tri_pos_t tpos_r, tpos_nxt, tpos_e;
  logic [CW-1:0]      col_r, col_nxt, col_e;
  logic [CW-1:0]      cnt_r, cnt_nxt, cnt_e;
  gmig_pkg::idx_t     base_r, base_nxt, base_e;
  logic               col_end;
  logic               cnt_end;

  always_comb begin
    // restart takes effect before the current request is served
    skirt_e = restart ? 1'b0 : skirt_r;
    done_e  = restart ? 1'b0 : done_r;
    tpos_e  = restart ? gmig_pkg::TRI_FIRST : tpos_r;
    col_e   = restart ? '0 : col_r;
    cnt_e   = restart ? '0 : cnt_r;
    base_e  = restart ? '0 : base_r;

    col_end = (gmig_pkg::idx_t'(col_e) + gmig_pkg::idx_t'(1)) == (n - gmig_pkg::idx_t'(1));
    cnt_end = (gmig_pkg::idx_t'(cnt_e) + gmig_pkg::idx_t'(1)) == (n - gmig_pkg::idx_t'(1));

    skirt_nxt = skirt_e;
    done_nxt  = done_e;
    tpos_nxt  = tpos_e;
    col_nxt   = col_e;
    cnt_nxt   = cnt_e;
    base_nxt  = base_e;
    last      = 1'b0;

    if (!done_e) begin
      if (!skirt_e) begin
        if (tpos_e == gmig_pkg::TRI_FIRST) begin
          tpos_nxt = gmig_pkg::tri_pos_t'(1);
        end else begin
          tpos_nxt = gmig_pkg::TRI_FIRST;
          if (col_end) begin
            col_nxt = '0;
            if (cnt_end) begin
              cnt_nxt   = '0;
              base_nxt  = '0;
              skirt_nxt = 1'b1;
            end else begin
              cnt_nxt  = CW'(cnt_e + 1'b1);
              base_nxt = base_e + n;
            end
          end else begin
            col_nxt = CW'(col_e + 1'b1);
          end
        end
      end else begin
        if (tpos_e != gmig_pkg::TRI_LFT_B) begin
          tpos_nxt = tpos_e + gmig_pkg::tri_pos_t'(1);
        end else begin
          tpos_nxt = gmig_pkg::TRI_FIRST;
          if (cnt_end) begin
            last     = 1'b1;
            done_nxt = 1'b1;
          end else begin
            cnt_nxt  = CW'(cnt_e + 1'b1);
            base_nxt = base_e + n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      skirt_r <= 1'b0;
      done_r  <= 1'b0;
      tpos_r  <= gmig_pkg::TRI_FIRST;
      col_r   <= '0;
      cnt_r   <= '0;
      base_r  <= '0;
    end else if (step) begin
      skirt_r <= skirt_nxt;
      done_r  <= done_nxt;
      tpos_r  <= tpos_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
    end
  end

  assign cur.skirt = skirt_e;
  assign cur.done  = done_e;
  assign cur.tpos  = tpos_e;
  assign cur.col   = gmig_pkg::idx_t'(col_e);
  assign cur.cnt   = gmig_pkg::idx_t'(cnt_e);
  assign cur.base  = base_e;

endmodule

[rtl/gmig_tri.sv]
// Vertex indices of the triangle at the current list position.
// Depends on gmig_pkg.
module gmig_tri (
  input  gmig_pkg::seq_t   cur,
  input  gmig_pkg::geom_t  geom,
  output gmig_pkg::tri_t   tri_o
);

  gmig_pkg::idx_t top, bot, i, e, one;

  always_comb begin
    one = gmig_pkg::idx_t'(1);
    top = cur.base + cur.col;
    bot = top + geom.n;
    i   = cur.cnt;
    e   = cur.base;
    if (!cur.skirt) begin
      if (cur.tpos == gmig_pkg::TRI_FIRST) begin
        tri_o.a = top;
        tri_o.b = top + one;
        tri_o.c = bot;
      end else begin
        tri_o.a = top + one;
        tri_o.b = bot + one;
        tri_o.c = bot;
      end
    end else begin
      case (cur.tpos)
        gmig_pkg::TRI_TOP_A: begin
          tri_o.a = geom.nn + i;
          tri_o.b = geom.nn + i + one;
          tri_o.c = i;
        end
        gmig_pkg::TRI_TOP_B: begin
          tri_o.a = geom.nn + i + one;
          tri_o.b = i + one;
          tri_o.c = i;
        end
        gmig_pkg::TRI_RGT_A: begin
          tri_o.a = e + geom.n - one;
          tri_o.b = geom.rgt + i;
          tri_o.c = e + (geom.n << 1) - one;
        end
        gmig_pkg::TRI_RGT_B: begin
          tri_o.a = geom.rgt + i;
          tri_o.b = geom.rgt + i + one;
          tri_o.c = e + (geom.n << 1) - one;
        end
        gmig_pkg::TRI_BTM_A: begin
          tri_o.a = geom.lrow + i;
          tri_o.b = geom.lrow + i + one;
          tri_o.c = geom.btm + i;
        end
        gmig_pkg::TRI_BTM_B: begin
          tri_o.a = geom.lrow + i + one;
          tri_o.b = geom.btm + i + one;
          tri_o.c = geom.btm + i;
        end
        gmig_pkg::TRI_LFT_A: begin
          tri_o.a = geom.lft + i;
          tri_o.b = e;
          tri_o.c = geom.lft + i + one;
        end
        default: begin
          tri_o.a = e;
          tri_o.b = e + geom.n;
          tri_o.c = geom.lft + i + one;
        end
      endcase
    end
  end

endmodule

[rtl/grid_mesh_index_generator_core.sv]
// Top level of the grid mesh index generator: handshakes, request and result
// registers. Depends on gmig_pkg, gmig_geom, gmig_seq and gmig_tri.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata[0] restart
//  out_    | out | out_tvalid/tready   | tdata a,b,c (17b each), tlast, tuser
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_data grid side (9b)
//
// One triangle per cycle sustained while results are taken; each request waits
// in the request register and is loaded into the result register on advance.
// The request register drains whenever the result register is empty or taken;
// a waiting result holds off new requests only once the request register is
// full as well.
// A side write restarts the list; requests are held off while the side
// constants (five small products) are registered. The same hold-off follows
// reset. Reset is synchronous, active low.
module grid_mesh_index_generator_core #(
  parameter int MAX_SIDE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gmig_pkg::IN_W-1:0]     in_tdata,   // [0] restart
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gmig_pkg::OUT_W-1:0]    out_tdata,  // [16:0] a, [33:17] b, [50:34] c
  output logic                          out_tlast,  // last_of_list
  output logic                          out_tuser,  // exhausted
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmig_pkg::SIDE_W-1:0]   cfg_data    // grid side
);

  logic                         req_valid_r;
  logic                         req_restart_r;
  logic                         out_valid_r;
  logic [gmig_pkg::OUT_W-1:0]   out_data_r;
  logic                         out_last_r;
  logic                         out_exh_r;
  logic                         in_acc;
  logic                         cfg_acc;
  logic                         advance;
  logic                         settling;
  logic                         last;
  gmig_pkg::geom_t              geom;
  gmig_pkg::seq_t               cur;
  gmig_pkg::tri_t               tri_w;
  gmig_pkg::tri_t               tri_out;

  // Configuration is always taken; it must only be written while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Advance the request when the result slot is free or being drained.
  assign advance   = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && !settling && (!req_valid_r || advance);
  assign in_acc    = in_tvalid && in_tready;

  gmig_geom #(.MAX_SIDE(MAX_SIDE)) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_acc),
    .wr_data  (cfg_data),
    .geom     (geom),
    .settling (settling)
  );

  gmig_seq #(.MAX_SIDE(MAX_SIDE)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_acc),
    .step    (advance),
    .restart (req_restart_r),
    .n       (geom.n),
    .cur     (cur),
    .last    (last)
  );

  gmig_tri u_tri (
    .cur   (cur),
    .geom  (geom),
    .tri_o (tri_w)
  );

  // Request register: hold a request until its result slot opens.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_acc) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_restart_r <= in_tdata[0];
    end
  end

  // An exhausted answer carries zero indices.
  assign tri_out = cur.done ? '0 : tri_w;

  // Result register: drop the valid once taken, reload on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {{gmig_pkg::OUT_PAD{1'b0}}, tri_out.c, tri_out.b, tri_out.a};
      out_last_r <= last;
      out_exh_r  <= cur.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_exh_r;

`ifndef SYNTHESIS
  a_exh_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && !out_tlast)
    else $error("exhausted result carries indices or last flag");

  a_cfg_holdoff : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_tready)
    else $error("request accepted before side constants settled");

  a_req_hold : assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && !advance |=> req_valid_r && $stable(req_restart_r))
    else $error("blocked request lost or changed");

  a_adv_fills : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced request produced no result");
`endif

endmodule

[sim/grid_mesh_index_generator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for grid_mesh_index_generator_core: triangle requests
// against an in-bench index predictor, with random stalls on both streams.
// Depends on gmig_pkg and the core RTL only.
module grid_mesh_index_generator_core_tb;

  localparam int MAX_SIDE      = 256;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;   // request register + result register + margin

  typedef struct packed {
    gmig_pkg::idx_t a;
    gmig_pkg::idx_t b;
    gmig_pkg::idx_t c;
    logic           last;
    logic           exhausted;
  } triangle_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [gmig_pkg::IN_W-1:0]     in_tdata   = '0;   // [0] restart, rest zero
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [gmig_pkg::OUT_W-1:0]    out_tdata;   // [16:0] a, [33:17] b, [50:34] c, rest zero
  logic                          out_tlast;   // last triangle of the list
  logic                          out_tuser;   // list already exhausted
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [gmig_pkg::SIDE_W-1:0]   cfg_data   = '0;

  grid_mesh_index_generator_core #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Index predictor state: the side register and the list position.
  logic [gmig_pkg::SIDE_W-1:0] side_reg = gmig_pkg::SIDE_RESET;
  logic                        in_skirt;
  int unsigned                 col_x;
  int unsigned                 row_i;      // row y in the grid, edge step i in the skirt
  gmig_pkg::tri_pos_t          tri_pos;
  logic                        list_done;

  triangle_t   pending_triangles[$];
  int unsigned requests_sent   = 0;
  int unsigned triangles_seen  = 0;
  int unsigned exhausted_seen  = 0;
  int unsigned list_ends_seen  = 0;
  int unsigned side_writes     = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned stall_left      = 0;
  int unsigned stall_mode      = 0;

  // Clamp the side register into the supported range.
  function automatic int unsigned active_side();
    int unsigned n;
    n = side_reg;
    if (n < gmig_pkg::MIN_SIDE) n = gmig_pkg::MIN_SIDE;
    if (n > MAX_SIDE) n = MAX_SIDE;
    return n;
  endfunction

  function automatic void restart_list();
    in_skirt  = 1'b0;
    col_x     = 0;
    row_i     = 0;
    tri_pos   = gmig_pkg::TRI_FIRST;
    list_done = 1'b0;
  endfunction

  // Work out the triangle one request returns and advance the list position.
  function automatic triangle_t next_triangle(input logic restart);
    int unsigned n, top, bot, nn, rgt, btm, lft, lrow, i;
    int unsigned v0, v1, v2;
    triangle_t   t;
    n = active_side();
    t = '0;
    if (restart) restart_list();
    if (list_done) begin
      t.exhausted = 1'b1;
      return t;
    end
    if (!in_skirt) begin
      top = row_i * n + col_x;
      bot = top + n;
      if (tri_pos == gmig_pkg::TRI_FIRST) begin
        v0 = top;     v1 = top + 1; v2 = bot;
        tri_pos = gmig_pkg::TRI_TOP_B;   // second triangle of the cell
      end else begin
        v0 = top + 1; v1 = bot + 1; v2 = bot;
        tri_pos = gmig_pkg::TRI_FIRST;
        if (col_x + 1 >= n - 1) begin
          col_x = 0;
          if (row_i + 1 >= n - 1) begin
            row_i    = 0;
            in_skirt = 1'b1;
          end else begin
            row_i++;
          end
        end else begin
          col_x++;
        end
      end
    end else begin
      i    = row_i;
      nn   = n * n;
      rgt  = nn + n;
      btm  = n * (n + 2);
      lft  = n * (n + 3);
      lrow = (n - 1) * n;
      case (tri_pos)
        gmig_pkg::TRI_TOP_A: begin
          v0 = nn + i;           v1 = nn + i + 1;    v2 = i;
        end
        gmig_pkg::TRI_TOP_B: begin
          v0 = nn + i + 1;       v1 = i + 1;         v2 = i;
        end
        gmig_pkg::TRI_RGT_A: begin
          v0 = n * (i + 1) - 1;  v1 = rgt + i;       v2 = n * (i + 2) - 1;
        end
        gmig_pkg::TRI_RGT_B: begin
          v0 = rgt + i;          v1 = rgt + i + 1;   v2 = n * (i + 2) - 1;
        end
        gmig_pkg::TRI_BTM_A: begin
          v0 = lrow + i;         v1 = lrow + i + 1;  v2 = btm + i;
        end
        gmig_pkg::TRI_BTM_B: begin
          v0 = lrow + i + 1;     v1 = btm + i + 1;   v2 = btm + i;
        end
        gmig_pkg::TRI_LFT_A: begin
          v0 = lft + i;          v1 = n * i;         v2 = lft + i + 1;
        end
        default: begin
          v0 = n * i;            v1 = n * (i + 1);   v2 = lft + i + 1;
        end
      endcase
      if (tri_pos != gmig_pkg::TRI_LFT_B) begin
        tri_pos = tri_pos + 1'b1;
      end else begin
        tri_pos = gmig_pkg::TRI_FIRST;
        if (row_i + 1 >= n - 1) begin
          t.last    = 1'b1;
          list_done = 1'b1;
        end else begin
          row_i++;
        end
      end
    end
    t.a = gmig_pkg::idx_t'(v0);
    t.b = gmig_pkg::idx_t'(v1);
    t.c = gmig_pkg::idx_t'(v2);
    return t;
  endfunction

  // Send one request; the sender runs in bursts with random gaps between them.
  task automatic send_request(input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {{(gmig_pkg::IN_W-1){1'b0}}, restart};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_triangles.push_back(next_triangle(restart));
    requests_sent++;
  endtask

  // Hold requests until every expected triangle has come back, then let the
  // pipeline settle.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_triangles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the side register; the block restarts its list on every write.
  task automatic write_side(input logic [gmig_pkg::SIDE_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_reg = value;
    restart_list();
    side_writes++;
  endtask

  // Reset side of 2: walk the whole ten-triangle list, request past its end,
  // then restart after exhaustion.
  task automatic test_default_side();
    repeat (10) send_request(1'b0);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_all_results();
  endtask

  // Largest side, out-of-range sides clamped both ways, restart mid-list.
  task automatic test_side_extremes();
    write_side(gmig_pkg::SIDE_W'(MAX_SIDE));
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    wait_all_results();
    write_side('1);
    repeat (2) send_request(1'b0);
    wait_all_results();
    write_side('0);
    repeat (2) send_request(1'b0);
    wait_all_results();
    write_side(gmig_pkg::SIDE_W'(1));
    repeat (2) send_request(1'b0);
    wait_all_results();
  endtask

  // Random sides, mostly small so lists run through the skirt to exhaustion;
  // sparse restarts and the odd pause until all results are back.
  task automatic test_random_lists();
    int unsigned sent, n, list_len, count, pause_at, pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        write_side(gmig_pkg::SIDE_W'($urandom_range(0, (1 << gmig_pkg::SIDE_W) - 1)));
      else if (pick == 1) write_side(gmig_pkg::SIDE_W'($urandom_range(41, MAX_SIDE)));
      else if (pick < 15) write_side(gmig_pkg::SIDE_W'($urandom_range(2, 8)));
      else                write_side(gmig_pkg::SIDE_W'($urandom_range(9, 24)));
      n = active_side();
      list_len = 2 * (n - 1) * (n - 1) + 8 * (n - 1);
      if (list_len > 200)                count = $urandom_range(20, 150);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, list_len);
      else                               count = list_len + $urandom_range(0, 4);
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, count - 1) : count;
      for (int unsigned k = 0; k < count; k++) begin
        if (k == pause_at) wait_all_results();
        send_request($urandom_range(0, 49) == 0);
      end
      sent += count;
      wait_all_results();
    end
  endtask

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Receiver stalls on its own pattern, checks each accepted triangle against
  // the oldest expectation, and watches the cycle limit.
  always @(posedge clk) begin : result_check
    triangle_t got, want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d triangles outstanding",
               cycle_count, pending_triangles.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if (rst_n && out_tvalid && out_tready) begin
        got.a         = out_tdata[gmig_pkg::IDX_W-1:0];
        got.b         = out_tdata[2*gmig_pkg::IDX_W-1:gmig_pkg::IDX_W];
        got.c         = out_tdata[3*gmig_pkg::IDX_W-1:2*gmig_pkg::IDX_W];
        got.last      = out_tlast;
        got.exhausted = out_tuser;
        if (pending_triangles.size() == 0) begin
          $display("%0t: unexpected triangle, expected none, actual %0d %0d %0d",
                   $time, got.a, got.b, got.c);
          fail_count++;
        end else begin
          want = pending_triangles.pop_front();
          report_field("vertex_a", want.a, got.a);
          report_field("vertex_b", want.b, got.b);
          report_field("vertex_c", want.c, got.c);
          report_field("last_of_list", want.last, got.last);
          report_field("exhausted", want.exhausted, got.exhausted);
        end
        triangles_seen++;
        if (got.exhausted) exhausted_seen++;
        if (got.last) list_ends_seen++;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    side_reg = gmig_pkg::SIDE_RESET;
    restart_list();
    @(posedge clk);
    test_default_side();
    test_side_extremes();
    test_random_lists();
    wait_all_results();
    $display("%0d requests, %0d triangles checked over %0d side writes",
             requests_sent, triangles_seen, side_writes);
    $display("%0d complete lists, %0d requests past the end", list_ends_seen, exhausted_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gmig_pkg.sv
rtl/gmig_geom.sv
rtl/gmig_seq.sv
rtl/gmig_tri.sv
rtl/grid_mesh_index_generator_core.sv
sim/grid_mesh_index_generator_core_tb.sv
